/* design/lmbr_pkg.sv */
// ----------------------------------------------------------------------------
// lmbr_pkg
// Shared types and codes for the lazy multiply-accumulate Barrett reducer.
// ----------------------------------------------------------------------------
package lmbr_pkg;

   // Item commands
   localparam logic CMD_ACC = 1'b0;
   localparam logic CMD_RED = 1'b1;

   // Register indexes on the csr port
   localparam logic [1:0] REG_MODULUS  = 2'd0;
   localparam logic [1:0] REG_RATIO_LO = 2'd1;
   localparam logic [1:0] REG_RATIO_HI = 2'd2;

   // Field widths fixed by the item format
   localparam int INDEX_W   = 12;
   localparam int WORD_W    = 64;
   localparam int MODULUS_W = 61;

   // Depth of the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic                 cmd;
      logic                 in_range;
      logic [INDEX_W-1:0]   index;
      logic [WORD_W-1:0]    factor_a;
      logic [WORD_W-1:0]    factor_b;
   } item_type;

   typedef struct packed {
      logic [MODULUS_W-1:0] modulus;
      logic [WORD_W-1:0]    ratio_lo;
      logic [WORD_W-1:0]    ratio_hi;
   } cfg_type;

   typedef struct packed {
      logic clearing;
   } status_type;

endpackage

/* design/lazy_mac_barrett_reduce.sv */
// ----------------------------------------------------------------------------
// lazy_mac_barrett_reduce
// Table of 128-bit accumulators with multiply-accumulate and Barrett reduce.
// ----------------------------------------------------------------------------
// After reset the block sweeps its accumulator table to zero, one entry per
// cycle; req_stall stays high during the sweep (csr writes are taken as
// ever). Items then flow through a four-deep queue into one sequencer built
// around a single 32x32 multiplier. An accumulate holds the sequencer for a
// pop, a table read, four partial products plus drain and a write back; a
// reduce holds it for a pop, a table read, five 64x64 products each followed
// by a combine step, and a final step to load the result register, longer
// while the previous result is still stalled. The shared multiplier sets
// this pace. Write the csr registers only while idle.
// ----------------------------------------------------------------------------
module lazy_mac_barrett_reduce #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [lmbr_pkg::INDEX_W-1:0]    req_coeff_index,
   input  logic [lmbr_pkg::WORD_W-1:0]     req_factor_a,
   input  logic [lmbr_pkg::WORD_W-1:0]     req_factor_b,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lmbr_pkg::INDEX_W-1:0]    rsp_out_index,
   output logic [lmbr_pkg::MODULUS_W-1:0]  rsp_residue,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [lmbr_pkg::WORD_W-1:0]     csr_wdata
);
   import lmbr_pkg::*;

   cfg_type    cfg_ff;
   status_type back_status;
   logic       pop;
   logic       head_valid;
   item_type   head_item;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.modulus  <= MODULUS_W'(2);
         cfg_ff.ratio_lo <= '0;
         cfg_ff.ratio_hi <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODULUS:  cfg_ff.modulus  <= csr_wdata[MODULUS_W-1:0];
            REG_RATIO_LO: cfg_ff.ratio_lo <= csr_wdata;
            REG_RATIO_HI: cfg_ff.ratio_hi <= csr_wdata;
            default:      cfg_ff          <= cfg_ff;
         endcase
      end
   end

   lmbr_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_coeff_index (req_coeff_index),
      .req_factor_a    (req_factor_a),
      .req_factor_b    (req_factor_b),
      .back_status     (back_status),
      .pop             (pop),
      .head_valid      (head_valid),
      .head_item       (head_item)
   );

   lmbr_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .status        (back_status),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_index (rsp_out_index),
      .rsp_residue   (rsp_residue)
   );

endmodule

/* design/lmbr_fifo.sv */
// ----------------------------------------------------------------------------
// lmbr_fifo
// Short item queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module lmbr_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lmbr_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output lmbr_pkg::item_type head_item
);
   import lmbr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type                entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff;
   logic [PTR_W-1:0]        rd_ptr_ff;
   logic [PTR_W:0]          count_ff;

   assign full       = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   // Store pushed words
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Advance pointers and track fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* design/lmbr_front.sv */
// ----------------------------------------------------------------------------
// lmbr_front
// Accepts request words, checks the index against the table, drops
// accumulates to missing entries and queues the rest for the back.
// ----------------------------------------------------------------------------
module lmbr_front #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [lmbr_pkg::INDEX_W-1:0]  req_coeff_index,
   input  logic [lmbr_pkg::WORD_W-1:0]   req_factor_a,
   input  logic [lmbr_pkg::WORD_W-1:0]   req_factor_b,
   input  lmbr_pkg::status_type          back_status,
   input  logic                          pop,
   output logic                          head_valid,
   output lmbr_pkg::item_type            head_item
);
   import lmbr_pkg::*;

   logic     full;
   logic     accept;
   logic     in_range;
   logic     push;
   item_type push_item;

   // Hold requests while the queue is full or the table is being cleared
   assign req_stall = full | back_status.clearing;
   assign accept    = req_valid & ~req_stall;

   // Classify: entry exists in the table
   assign in_range = (17'(req_coeff_index) < 17'(TABLE_DEPTH));

   // Drop accumulates to missing entries, they have no effect
   assign push = accept & (in_range | (req_cmd == CMD_RED));

   always_comb begin
      push_item.cmd      = req_cmd;
      push_item.in_range = in_range;
      push_item.index    = req_coeff_index;
      push_item.factor_a = req_factor_a;
      push_item.factor_b = req_factor_b;
   end

   lmbr_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

endmodule

/* design/lmbr_back.sv */
// ----------------------------------------------------------------------------
// lmbr_back
// Accumulator table and arithmetic sequencer. One shared 32x32 multiplier
// builds each 64x64 product over four partial products; reduce items chain
// five such products into the Barrett estimate and the residue.
// ----------------------------------------------------------------------------
module lmbr_back #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lmbr_pkg::cfg_type               cfg,
   output lmbr_pkg::status_type            status,
   input  logic                            head_valid,
   input  lmbr_pkg::item_type              head_item,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lmbr_pkg::INDEX_W-1:0]    rsp_out_index,
   output logic [lmbr_pkg::MODULUS_W-1:0]  rsp_residue
);
   import lmbr_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_MUL, ST_COMB, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      STEP_ACC, STEP_P0, STEP_P1, STEP_P2, STEP_P3, STEP_P4
   } step_type;

   state_type          state_ff;
   step_type           step_ff;
   logic [IDX_W-1:0]   clr_cnt_ff;
   item_type           item_ff;
   logic [63:0]        x_lo_ff, x_hi_ff;
   logic [63:0]        opa_ff, opb_ff;
   logic [2:0]         k_ff;
   logic [1:0]         ppk_ff;
   logic [63:0]        pp_ff;
   logic [127:0]       prod_ff;
   logic [63:0]        t_ff, sum_ff, part_ff, c2_ff, diff_ff;
   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [MODULUS_W-1:0] rsp_residue_ff;

   // Accumulator table
   logic [127:0]       mem [TABLE_DEPTH];
   logic [127:0]       rdata_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [127:0]       mem_wdata;
   logic [IDX_W-1:0]   mem_raddr;
   logic [IDX_W-1:0]   item_addr;
   logic [15:0]        head_ext, item_ext;

   logic [63:0]        pp_in;
   logic [127:0]       pp_shift;
   logic [64:0]        sum_in;
   logic [64:0]        sum2_in;
   logic [63:0]        est_in;
   logic [63:0]        q_ext;
   logic [63:0]        corr;
   logic               out_free;

   assign head_ext  = 16'(head_item.index);
   assign item_ext  = 16'(item_ff.index);
   assign mem_raddr = head_ext[IDX_W-1:0];
   assign item_addr = item_ext[IDX_W-1:0];
   assign q_ext     = 64'(cfg.modulus);

   assign status.clearing = (state_ff == ST_CLEAR);
   assign pop = (state_ff == ST_IDLE) & head_valid;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // Table write: clear sweep, clear on reduce, or updated sum
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = item_addr;
      mem_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
         end
         ST_READ: begin
            mem_we = (item_ff.cmd == CMD_RED) & item_ff.in_range;
         end
         ST_COMB: begin
            mem_we    = (step_ff == STEP_ACC);
            mem_wdata = {x_hi_ff, x_lo_ff} + prod_ff;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // Partial product and its weight
   assign pp_in = 64'(k_ff[0] ? opa_ff[63:32] : opa_ff[31:0])
                * 64'(k_ff[1] ? opb_ff[63:32] : opb_ff[31:0]);

   always_comb begin
      unique case (2'(ppk_ff[0]) + 2'(ppk_ff[1]))
         2'd0:    pp_shift = 128'(pp_ff);
         2'd1:    pp_shift = 128'(pp_ff) << 32;
         default: pp_shift = 128'(pp_ff) << 64;
      endcase
   end

   // Estimate carry chain pieces
   assign sum_in  = 65'(prod_ff[63:0]) + 65'(t_ff);
   assign sum2_in = 65'(sum_ff) + 65'(prod_ff[63:0]);
   assign est_in  = prod_ff[63:0] + part_ff + c2_ff;
   assign corr    = (diff_ff >= q_ext) ? diff_ff - q_ext : diff_ff;

   // Sequencer: state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_ACC;
         k_ff         <= '0;
      end else begin
         // drop a taken result unless a new one is loaded in its place
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == LAST_ENTRY) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (head_valid) begin
                  item_ff  <= head_item;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               x_lo_ff <= item_ff.in_range ? rdata_ff[63:0]   : '0;
               x_hi_ff <= item_ff.in_range ? rdata_ff[127:64] : '0;
               k_ff    <= '0;
               if (item_ff.cmd == CMD_ACC) begin
                  opa_ff  <= item_ff.factor_a;
                  opb_ff  <= item_ff.factor_b;
                  step_ff <= STEP_ACC;
               end else begin
                  opa_ff  <= item_ff.in_range ? rdata_ff[63:0] : '0;
                  opb_ff  <= cfg.ratio_lo;
                  step_ff <= STEP_P0;
               end
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (k_ff != 3'd4) begin
                  pp_ff  <= pp_in;
                  ppk_ff <= k_ff[1:0];
               end
               if (k_ff != 3'd0) begin
                  prod_ff <= ((k_ff == 3'd1) ? '0 : prod_ff) + pp_shift;
               end
               k_ff <= k_ff + 1'b1;
               if (k_ff == 3'd4) state_ff <= ST_COMB;
            end
            ST_COMB: begin
               k_ff <= '0;
               unique case (step_ff)
                  STEP_ACC: state_ff <= ST_IDLE;
                  STEP_P0: begin
                     t_ff     <= prod_ff[127:64];
                     opa_ff   <= x_lo_ff;
                     opb_ff   <= cfg.ratio_hi;
                     step_ff  <= STEP_P1;
                     state_ff <= ST_MUL;
                  end
                  STEP_P1: begin
                     sum_ff   <= sum_in[63:0];
                     part_ff  <= prod_ff[127:64] + 64'(sum_in[64]);
                     opa_ff   <= x_hi_ff;
                     opb_ff   <= cfg.ratio_lo;
                     step_ff  <= STEP_P2;
                     state_ff <= ST_MUL;
                  end
                  STEP_P2: begin
                     c2_ff    <= prod_ff[127:64] + 64'(sum2_in[64]);
                     opa_ff   <= x_hi_ff;
                     opb_ff   <= cfg.ratio_hi;
                     step_ff  <= STEP_P3;
                     state_ff <= ST_MUL;
                  end
                  STEP_P3: begin
                     opa_ff   <= est_in;
                     opb_ff   <= q_ext;
                     step_ff  <= STEP_P4;
                     state_ff <= ST_MUL;
                  end
                  default: begin
                     diff_ff  <= x_lo_ff - prod_ff[63:0];
                     state_ff <= ST_OUT;
                  end
               endcase
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_index_ff   <= item_ff.index;
                  rsp_residue_ff <= corr[MODULUS_W-1:0];
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_residue   = rsp_residue_ff;

endmodule

/* design/lmbr_checker.sv */
// ----------------------------------------------------------------------------
// lmbr_checker
// Port-level checks on the reducer, bound to the top level.
// ----------------------------------------------------------------------------
module lmbr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_out_index,
   input logic [60:0] rsp_residue,
   input logic        csr_ready
);

   // Table sweep follows reset, so requests are held
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall) else $error("request taken during table sweep");

   // No result straight out of reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result after reset");

   // Held result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_residue)
         && $stable(rsp_out_index)) else $error("stalled result changed");

   // Register port never back-pressures
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready) else $error("csr port not ready");

endmodule

bind lazy_mac_barrett_reduce lmbr_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_index (rsp_out_index),
   .rsp_residue   (rsp_residue),
   .csr_ready     (csr_ready)
);

/* tb/lazy_mac_barrett_reduce_tb.sv */
// ----------------------------------------------------------------------------
// lazy_mac_barrett_reduce_tb
// Drives accumulate and reduce words into the accumulator table, predicts
// every residue with a local 128-bit Barrett model and checks each result
// word in order, under several idle and stall mixes and register settings.
// ----------------------------------------------------------------------------
module lazy_mac_barrett_reduce_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lmbr_pkg::*;

   localparam int  TABLE_DEPTH = 4096;
   localparam int  CYCLE_LIMIT = 1500000;
   localparam int  DRAIN_WAIT  = 64;

   typedef struct {
      logic               cmd;
      logic [INDEX_W-1:0] idx;
      logic [WORD_W-1:0]  fa;
      logic [WORD_W-1:0]  fb;
      bit                 typed;
      logic [MODULUS_W-1:0] res;
   } stim_row_type;

   typedef struct {
      logic [INDEX_W-1:0]   idx;
      logic [MODULUS_W-1:0] res;
      bit                   typed;
      logic [MODULUS_W-1:0] typed_res;
   } residue_word_type;

   logic                 clock, reset;
   logic                 req_valid, req_stall, req_cmd;
   logic [INDEX_W-1:0]   req_coeff_index;
   logic [WORD_W-1:0]    req_factor_a, req_factor_b;
   logic                 rsp_valid, rsp_stall;
   logic [INDEX_W-1:0]   rsp_out_index;
   logic [MODULUS_W-1:0] rsp_residue;
   logic                 csr_valid, csr_ready;
   logic [1:0]           csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   // model state
   logic [127:0]         acc_table [TABLE_DEPTH];
   logic [MODULUS_W-1:0] mod_q;
   logic [WORD_W-1:0]    ratio_lo, ratio_hi;

   residue_word_type pending_residues[$];
   int  errors = 0;
   int  cycles = 0;
   int  idle_pct = 0, stall_pct = 0;

   lazy_mac_barrett_reduce #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // truncated Barrett estimate, then one conditional correction
   function automatic logic [MODULUS_W-1:0] barrett_residue(logic [127:0] x);
      logic [63:0]  x0, x1, lo_hi, sum, sum2, part_hi, c2, est, diff, q;
      logic [127:0] p;
      x0 = x[63:0];
      x1 = x[127:64];
      q = {3'b0, mod_q};
      p = x0 * ratio_lo;
      lo_hi = p[127:64];
      p = x0 * ratio_hi;
      sum = p[63:0] + lo_hi;
      part_hi = p[127:64] + ((sum < p[63:0]) ? 64'd1 : 64'd0);
      p = x1 * ratio_lo;
      sum2 = sum + p[63:0];
      c2 = p[127:64] + ((sum2 < sum) ? 64'd1 : 64'd0);
      est = x1 * ratio_hi + part_hi + c2;
      diff = x0 - est * q;
      if (diff >= q) begin
         diff = diff - q;
      end
      return diff[MODULUS_W-1:0];
   endfunction

   // update the table and queue the expected word for a reduce
   task automatic predict_item(stim_row_type r);
      residue_word_type w;
      logic [127:0] x;
      if (r.cmd == CMD_ACC) begin
         if (r.idx < TABLE_DEPTH) begin
            acc_table[r.idx] = acc_table[r.idx] + 128'(r.fa) * 128'(r.fb);
         end
      end else begin
         x = 128'd0;
         if (r.idx < TABLE_DEPTH) begin
            x = acc_table[r.idx];
            acc_table[r.idx] = 128'd0;
         end
         w.idx = r.idx;
         w.res = barrett_residue(x);
         w.typed = r.typed;
         w.typed_res = r.res;
         pending_residues.push_back(w);
      end
   endtask

   // drive one word and wait for acceptance
   task automatic send_item(stim_row_type r);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_coeff_index <= r.idx;
      req_factor_a <= r.fa;
      req_factor_b <= r.fb;
      do @(posedge clock); while (req_stall);
      predict_item(r);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [WORD_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MODULUS:  mod_q = val[MODULUS_W-1:0];
         REG_RATIO_LO: ratio_lo = val;
         REG_RATIO_HI: ratio_hi = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // wait out every expected word plus the tail of any accumulate
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_residues.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // set modulus and its matching ratio, optionally corrupted
   task automatic set_modulus(logic [MODULUS_W-1:0] q, bit scramble);
      logic [128:0] r;
      r = (129'd1 << 128) / 129'(q);
      wait_idle();
      write_reg(REG_MODULUS, 64'(q));
      write_reg(REG_RATIO_LO, scramble ? {$urandom, $urandom} : r[63:0]);
      write_reg(REG_RATIO_HI, scramble ? {$urandom, $urandom} : r[127:64]);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(3))
         0: return 64'hFFFF_FFFF_FFFF_FFFF;
         1: return 64'(0 + $urandom_range(3));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      residue_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_residues.size() == 0) begin
            $display("%0t: unexpected word index %0d residue %h", $time,
                     rsp_out_index, rsp_residue);
            errors++;
         end else begin
            w = pending_residues.pop_front();
            if (rsp_out_index !== w.idx) begin
               $display("%0t: index expected %0d actual %0d", $time, w.idx,
                        rsp_out_index);
               errors++;
            end
            if (rsp_residue !== w.res) begin
               $display("%0t: residue expected %h actual %h", $time, w.res,
                        rsp_residue);
               errors++;
            end else if (w.typed && rsp_residue !== w.typed_res) begin
               $display("%0t: residue expected %h actual %h", $time,
                        w.typed_res, rsp_residue);
               errors++;
            end
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("lazy_mac_barrett_reduce_tb: done, errors");
         $finish;
      end
   end

   initial begin
      stim_row_type table_rows[$];
      stim_row_type r;
      logic [INDEX_W-1:0] hot [8];
      int n;
      req_valid = 1'b0; req_cmd = CMD_ACC; req_coeff_index = '0;
      req_factor_a = '0; req_factor_b = '0;
      csr_valid = 1'b0; csr_index = REG_MODULUS; csr_wdata = '0;
      rsp_stall = 1'b0;
      mod_q = 61'd2; ratio_lo = '0; ratio_hi = '0;
      foreach (acc_table[i]) acc_table[i] = 128'd0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows; residues typed in only where obvious
      table_rows = '{
         '{CMD_RED, 12'd0,    64'd0, 64'd0, 1'b1, 61'd0},
         '{CMD_RED, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5, 1'b1, 61'd0},
         '{CMD_ACC, 12'd1,    64'd1, 64'd1, 1'b0, 61'd0},
         '{CMD_RED, 12'd1,    64'd0, 64'd0, 1'b1, 61'd1},
         '{CMD_ACC, 12'd2,    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                1'b0, 61'd0},
         '{CMD_ACC, 12'd2,    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                1'b0, 61'd0},
         '{CMD_RED, 12'd2,    64'd0, 64'd0, 1'b0, 61'd0},
         '{CMD_RED, 12'd2,    64'd0, 64'd0, 1'b1, 61'd0},
         '{CMD_ACC, 12'd4095, 64'd7, 64'd9, 1'b0, 61'd0},
         '{CMD_RED, 12'd4095, 64'd1, 64'd1, 1'b0, 61'd0}
      };
      foreach (table_rows[i]) send_item(table_rows[i]);

      // real prime, largest modulus
      set_modulus(61'h1FFF_FFFF_FFFF_FFFF, 1'b0);
      table_rows = '{
         '{CMD_ACC, 12'd5, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                             1'b0, 61'd0},
         '{CMD_ACC, 12'd5, 64'h8000_0000_0000_0000, 64'd3, 1'b0, 61'd0},
         '{CMD_RED, 12'd5, 64'd0, 64'd0, 1'b0, 61'd0},
         '{CMD_ACC, 12'd6, 64'h1FFF_FFFF_FFFF_FFFF, 64'd1, 1'b0, 61'd0},
         '{CMD_RED, 12'd6, 64'd0, 64'd0, 1'b1, 61'd0}
      };
      foreach (table_rows[i]) send_item(table_rows[i]);

      // random phases: idle and stall mix, register setting, index spread
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 45; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 45; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase
         case (ph)
            0: set_modulus(61'd3, 1'b0);
            2: set_modulus(61'd2, 1'b0);
            4: set_modulus(61'h0FFF_FFFF_FFFF_FFEF, 1'b0);
            5: set_modulus(61'(0 + $urandom_range(1)), 1'b1);
            6: set_modulus(61'({$urandom, $urandom}) | 61'h1, 1'b1);
            7: set_modulus(61'({$urandom, $urandom}) | 61'h2, 1'b0);
            default: ;
         endcase
         foreach (hot[k]) hot[k] = (k == 0) ? 12'd4095 : 12'($urandom);
         for (n = 0; n < 50; n++) begin
            r.typed = 1'b0;
            r.res = '0;
            r.idx = ($urandom_range(9) == 0) ? 12'($urandom) : hot[$urandom_range(7)];
            r.cmd = ($urandom_range(3) == 0) ? CMD_RED : CMD_ACC;
            r.fa = rand_word();
            r.fb = rand_word();
            send_item(r);
         end
         // hold off until the block has drained
         if (ph == 3) begin
            wait_idle();
         end
      end

      wait_idle();
      if (errors == 0) begin
         $display("lazy_mac_barrett_reduce_tb: done, clean");
      end else begin
         $display("lazy_mac_barrett_reduce_tb: done, errors");
      end
      $finish;
   end
endmodule

/* files.f */
design/lmbr_pkg.sv
design/lmbr_fifo.sv
design/lmbr_front.sv
design/lmbr_back.sv
design/lazy_mac_barrett_reduce.sv
design/lmbr_checker.sv
tb/lazy_mac_barrett_reduce_tb.sv
